// ===== design/jfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// jfcc_pkg
// Shared constants, codes and payload types of the JSON frame completeness
// checker.
// ----------------------------------------------------------------------------
package jfcc_pkg;

    localparam int MAX_NEST   = 255;
    localparam int COUNT_BITS = 20;
    localparam int LEN_BITS   = 20;
    localparam int DEPTH_BITS = 8;
    localparam int CMP_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

    localparam logic [DEPTH_BITS-1:0] NEST_LIMIT =
        DEPTH_BITS'((MAX_NEST > 255) ? 255 : MAX_NEST);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic                CHECK_BRACKETS_RESET = 1'b1;
    localparam logic [LEN_BITS-1:0] MAX_LENGTH_RESET     = LEN_BITS'(100000);

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_FIRST = 3'd1,
        ERR_CLOSE = 3'd2,
        ERR_LONG  = 3'd3,
        ERR_NEST  = 3'd4
    } err_t;

    typedef enum logic {
        REG_CHECK_BRACKETS = 1'b0,
        REG_MAX_LENGTH     = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic                  complete;
        err_t                  error_code;
        logic [DEPTH_BITS-1:0] brace_level;
        logic [DEPTH_BITS-1:0] bracket_level;
        logic                  inside_string;
    } result_t;

    typedef struct packed {
        logic                check_brackets;
        logic [LEN_BITS-1:0] max_length;
    } cfg_t;

endpackage

// ===== design/jfcc_if.sv =====
// ----------------------------------------------------------------------------
// jfcc_if
// Valid/ready channels for request bytes and per-byte results.
// ----------------------------------------------------------------------------
interface jfcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface jfcc_result_if;
    logic       valid;
    logic       ready;
    logic       complete;
    logic [2:0] error_code;
    logic [7:0] brace_level;
    logic [7:0] bracket_level;
    logic       inside_string;

    modport source (
        output valid, output complete, output error_code, output brace_level,
        output bracket_level, output inside_string, input ready
    );
    modport sink (
        input valid, input complete, input error_code, input brace_level,
        input bracket_level, input inside_string, output ready
    );
endinterface

// ===== design/jfcc_in_reg.sv =====
// ----------------------------------------------------------------------------
// jfcc_in_reg
// Input register: holds one accepted byte until the engine takes it.
// ----------------------------------------------------------------------------
module jfcc_in_reg
    import jfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jfcc_byte_if.sink   byte_ch,
    input  logic        advance,
    output item_t       item,
    output logic        item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign byte_ch.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_ch.ready)
        begin
            valid_next = byte_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            item_reg.data_byte <= byte_ch.data_byte;
            item_reg.restart   <= byte_ch.restart;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== design/jfcc_engine.sv =====
// ----------------------------------------------------------------------------
// jfcc_engine
// Message state and the per-byte update of depths, flags, count and error.
// ----------------------------------------------------------------------------
module jfcc_engine
    import jfcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    logic [DEPTH_BITS-1:0] brace_reg,   brace_next;
    logic [DEPTH_BITS-1:0] bracket_reg, bracket_next;
    logic                  string_reg,  string_next;
    logic                  escape_reg,  escape_next;
    err_t                  error_reg,   error_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;

    logic                  starting;
    logic [DEPTH_BITS-1:0] brace_v;
    logic [DEPTH_BITS-1:0] bracket_v;
    logic                  string_v;
    logic                  escape_v;
    err_t                  error_v;
    err_t                  err;
    logic [COUNT_BITS-1:0] count_v;
    logic                  done;

    always_comb
    begin
        starting  = item.restart || (count_reg == '0);
        brace_v   = starting ? '0 : brace_reg;
        bracket_v = starting ? '0 : bracket_reg;
        string_v  = starting ? 1'b0 : string_reg;
        escape_v  = starting ? 1'b0 : escape_reg;
        error_v   = starting ? ERR_NONE : error_reg;
        count_v   = starting ? '0 : count_reg;
        err       = ERR_NONE;
        done      = 1'b0;

        if (error_v == ERR_NONE)
        begin
            if (count_v != COUNT_MAX)
            begin
                count_v = count_v + 1'b1;
            end

            if (starting && item.data_byte != CH_LBRACE)
            begin
                err = ERR_FIRST;
            end
            else if (escape_v)
            begin
                escape_v = 1'b0;
            end
            else if (item.data_byte == CH_BSLASH)
            begin
                escape_v = 1'b1;
            end
            else if (item.data_byte == CH_QUOTE)
            begin
                string_v = !string_v;
            end
            else if (!string_v)
            begin
                case (item.data_byte)
                    CH_LBRACE:
                    begin
                        if (brace_v >= NEST_LIMIT)
                            err = ERR_NEST;
                        else
                            brace_v = brace_v + 1'b1;
                    end
                    CH_RBRACE:
                    begin
                        if (brace_v == '0)
                            err = ERR_CLOSE;
                        else
                            brace_v = brace_v - 1'b1;
                    end
                    CH_LBRACK:
                    begin
                        if (cfg.check_brackets)
                        begin
                            if (bracket_v >= NEST_LIMIT)
                                err = ERR_NEST;
                            else
                                bracket_v = bracket_v + 1'b1;
                        end
                    end
                    CH_RBRACK:
                    begin
                        if (cfg.check_brackets)
                        begin
                            if (bracket_v == '0)
                                err = ERR_CLOSE;
                            else
                                bracket_v = bracket_v - 1'b1;
                        end
                    end
                    default:
                    begin
                        err = ERR_NONE;
                    end
                endcase
            end

            if (err == ERR_NONE)
            begin
                done = (brace_v == '0) && (bracket_v == '0) && !string_v;
                if (!done && (CMP_BITS'(count_v) > CMP_BITS'(cfg.max_length)))
                begin
                    err = ERR_LONG;
                end
            end
            error_v = err;
        end

        result.complete      = done;
        result.error_code    = error_v;
        result.brace_level   = brace_v;
        result.bracket_level = bracket_v;
        result.inside_string = string_v;

        if (done)
        begin
            brace_next   = '0;
            bracket_next = '0;
            string_next  = 1'b0;
            escape_next  = 1'b0;
            error_next   = ERR_NONE;
            count_next   = '0;
        end
        else
        begin
            brace_next   = brace_v;
            bracket_next = bracket_v;
            string_next  = string_v;
            escape_next  = escape_v;
            error_next   = error_v;
            count_next   = count_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brace_reg   <= '0;
            bracket_reg <= '0;
            string_reg  <= 1'b0;
            escape_reg  <= 1'b0;
            error_reg   <= ERR_NONE;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            brace_reg   <= brace_next;
            bracket_reg <= bracket_next;
            string_reg  <= string_next;
            escape_reg  <= escape_next;
            error_reg   <= error_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== design/jfcc_out_reg.sv =====
// ----------------------------------------------------------------------------
// jfcc_out_reg
// Result register: holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module jfcc_out_reg
    import jfcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jfcc_result_if.source result_ch,
    input  result_t      result,
    input  logic         advance,
    output logic         can_load
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign result_ch.valid         = valid_reg;
    assign result_ch.complete      = result_reg.complete;
    assign result_ch.error_code    = result_reg.error_code;
    assign result_ch.brace_level   = result_reg.brace_level;
    assign result_ch.bracket_level = result_reg.bracket_level;
    assign result_ch.inside_string = result_reg.inside_string;

endmodule

// ===== design/json_frame_completeness_checker.sv =====
// ----------------------------------------------------------------------------
// json_frame_completeness_checker
// Reports after each request byte whether the message so far is one complete
// JSON object, with depths, string flag and a sticky error code.
// A result is registered in the output register after its byte has passed the input register and the engine.
// Takes one byte per cycle while the result sink accepts; back-pressure on the result channel stalls it.
// Reset clears the message state and loads check_brackets = 1 and
// max_length = 100000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_frame_completeness_checker
    import jfcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    jfcc_byte_if.sink           byte_ch,
    jfcc_result_if.source       result_ch,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [LEN_BITS-1:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    advance;
    result_t result;

    assign advance = item_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_brackets <= CHECK_BRACKETS_RESET;
            cfg_reg.max_length     <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_CHECK_BRACKETS: cfg_reg.check_brackets <= cfg_data[0];
                REG_MAX_LENGTH:     cfg_reg.max_length     <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    jfcc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    jfcc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    jfcc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .result_ch (result_ch),
        .result    (result),
        .advance   (advance),
        .can_load  (can_load)
    );

endmodule
